@@ rtl/core/evp_pkg.sv @@
package evp_pkg;

    localparam int MAX_TAGS = 8;

    // byte offset counter peaks at 16 + 4*MAX_TAGS - 3
    localparam int POS_W = $clog2(16 + 4 * MAX_TAGS + 3);
    localparam int TAG_W = $clog2(MAX_TAGS + 1);

    localparam int NUM_REGS = 6;
    localparam int NUM_INNER = 5;
    localparam int ADDR_W = 5;

    localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_TCI_LO = POS_W'(15);
    localparam logic [POS_W-1:0] POS_TAGS = POS_W'(16);

    localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHTYPE_IPV6 = 16'h86dd;
    localparam logic [15:0] VID_MASK = 16'h0fff;

    localparam logic [2:0] ST_NOT_VLAN = 3'd0;
    localparam logic [2:0] ST_IPV4 = 3'd1;
    localparam logic [2:0] ST_IPV6 = 3'd2;
    localparam logic [2:0] ST_OTHER = 3'd3;
    localparam logic [2:0] ST_TRUNC = 3'd4;
    localparam logic [2:0] ST_TOO_MANY = 3'd5;

    localparam logic [1:0] CLS_ONE = 2'd0;
    localparam logic [1:0] CLS_TWO = 2'd1;
    localparam logic [1:0] CLS_MORE = 2'd2;

    localparam logic [2:0] REG_OUTER_TPID = 3'd0;
    localparam logic [2:0] REG_TPID_A = 3'd1;
    localparam logic [2:0] REG_TPID_B = 3'd2;
    localparam logic [2:0] REG_TPID_C = 3'd3;
    localparam logic [2:0] REG_TPID_D = 3'd4;
    localparam logic [2:0] REG_TPID_E = 3'd5;

    localparam logic [15:0] RST_OUTER_TPID = 16'h8100;
    localparam logic [15:0] RST_TPID_A = 16'h8100;
    localparam logic [15:0] RST_TPID_B = 16'h88a8;
    localparam logic [15:0] RST_TPID_C = 16'h9100;
    localparam logic [15:0] RST_TPID_D = 16'h9200;
    localparam logic [15:0] RST_TPID_E = 16'h9300;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] outer_tci;
        logic [11:0] vlan_id;
        logic [3:0]  tag_layers;
        logic [1:0]  tag_class;
        logic [15:0] l3_ethertype;
        logic [5:0]  l3_offset;
    } t_out;

    typedef struct packed {
        logic [15:0]                outer_tpid;
        logic [NUM_INNER-1:0][15:0] tag_tpid;
    } t_cfg;

    function automatic logic [1:0] tag_class_of(input logic [TAG_W-1:0] n);
        logic [1:0] c;
        if (n <= TAG_W'(1)) begin
            c = CLS_ONE;
        end else if (n == TAG_W'(2)) begin
            c = CLS_TWO;
        end else begin
            c = CLS_MORE;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/evp_parser.sv @@
module evp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  evp_pkg::t_in      i_word,
    input  evp_pkg::t_cfg     i_cfg,
    output logic              o_emit,
    output evp_pkg::t_out     o_res
);

    logic [evp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [evp_pkg::TAG_W-1:0] r_tags, n_tags;
    logic [15:0]               r_outer, n_outer;
    logic [7:0]                r_hold, n_hold;
    logic                      r_decided, n_decided;

    logic [15:0] pair;
    logic        is_tpid;

    assign pair = {r_hold, i_word.data_byte};

    always_comb begin
        is_tpid = 1'b0;
        for (int i = 0; i < evp_pkg::NUM_INNER; i++) begin
            if (i_cfg.tag_tpid[i] == pair) begin
                is_tpid = 1'b1;
            end
        end
    end

    function automatic evp_pkg::t_out make_res(
        input logic [2:0]                st,
        input logic [15:0]               tci,
        input logic [evp_pkg::TAG_W-1:0] layers,
        input logic [1:0]                cls,
        input logic [15:0]               l3type,
        input logic [5:0]                l3off
    );
        evp_pkg::t_out r;
        r.status       = st;
        r.outer_tci    = tci;
        r.vlan_id      = 12'(tci & evp_pkg::VID_MASK);
        r.tag_layers   = 4'(layers);
        r.tag_class    = cls;
        r.l3_ethertype = l3type;
        r.l3_offset    = l3off;
        return r;
    endfunction

    always_comb begin
        n_pos     = r_pos;
        n_tags    = r_tags;
        n_outer   = r_outer;
        n_hold    = r_hold;
        n_decided = r_decided;
        o_emit    = 1'b0;
        o_res     = make_res(evp_pkg::ST_NOT_VLAN, 16'd0, '0, evp_pkg::CLS_ONE, 16'd0, 6'd0);

        if (!r_decided) begin
            if (!r_pos[0]) begin
                n_hold = i_word.data_byte;
            end else if (r_pos == evp_pkg::POS_ETYPE_LO) begin
                if (pair != i_cfg.outer_tpid) begin
                    o_emit    = 1'b1;
                    n_decided = 1'b1;
                end else begin
                    n_tags = evp_pkg::TAG_W'(1);
                end
            end else if (r_pos == evp_pkg::POS_TCI_LO) begin
                n_outer = pair;
            end else if (r_pos >= evp_pkg::POS_TAGS && r_pos[1:0] == 2'b01) begin
                // type field of the next header: another tag or the L3 type
                if (is_tpid) begin
                    if (r_tags >= evp_pkg::TAG_W'(evp_pkg::MAX_TAGS)) begin
                        o_emit    = 1'b1;
                        n_decided = 1'b1;
                        o_res     = make_res(evp_pkg::ST_TOO_MANY, r_outer,
                                             evp_pkg::TAG_W'(evp_pkg::MAX_TAGS),
                                             evp_pkg::CLS_MORE, 16'd0, 6'd0);
                    end else begin
                        n_tags = r_tags + evp_pkg::TAG_W'(1);
                    end
                end else begin
                    o_emit    = 1'b1;
                    n_decided = 1'b1;
                    o_res     = make_res((pair == evp_pkg::ETHTYPE_IPV4) ? evp_pkg::ST_IPV4 :
                                         (pair == evp_pkg::ETHTYPE_IPV6) ? evp_pkg::ST_IPV6 :
                                         evp_pkg::ST_OTHER,
                                         r_outer, r_tags, evp_pkg::tag_class_of(r_tags),
                                         pair, 6'(r_pos + evp_pkg::POS_W'(1)));
                end
            end
            if (!n_decided) begin
                n_pos = r_pos + evp_pkg::POS_W'(1);
            end
        end

        if (i_word.last_byte) begin
            if (!n_decided) begin
                o_emit = 1'b1;
                o_res  = make_res(evp_pkg::ST_TRUNC, n_outer, n_tags,
                                  evp_pkg::tag_class_of(n_tags), 16'd0, 6'd0);
            end
            n_pos     = '0;
            n_tags    = '0;
            n_outer   = '0;
            n_hold    = '0;
            n_decided = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_tags    <= '0;
            r_outer   <= '0;
            r_hold    <= '0;
            r_decided <= 1'b0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_tags    <= n_tags;
            r_outer   <= n_outer;
            r_hold    <= n_hold;
            r_decided <= n_decided;
        end
    end

endmodule

@@ rtl/core/ethernet_vlan_stack_parser.sv @@
// A frame's result word is registered; it appears in the cycle after its deciding byte.
// One byte per cycle unless stalled; the frame state updates in one pass per byte.
// The input stalls only while a result is held and the output side stalls.
// Reset (synchronous, active low) clears the frame state, drops any held result
// and loads the TPID registers with 0x8100, 0x8100, 0x88a8, 0x9100, 0x9200, 0x9300.
module ethernet_vlan_stack_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  evp_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output evp_pkg::t_out              o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [evp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    evp_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          cfg_wr;

    logic          in_accept;
    logic          emit;
    evp_pkg::t_out res;

    logic          r_out_valid;
    evp_pkg::t_out r_out_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[evp_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_tpid  <= evp_pkg::RST_OUTER_TPID;
            r_cfg.tag_tpid[0] <= evp_pkg::RST_TPID_A;
            r_cfg.tag_tpid[1] <= evp_pkg::RST_TPID_B;
            r_cfg.tag_tpid[2] <= evp_pkg::RST_TPID_C;
            r_cfg.tag_tpid[3] <= evp_pkg::RST_TPID_D;
            r_cfg.tag_tpid[4] <= evp_pkg::RST_TPID_E;
        end else if (cfg_wr) begin
            case (reg_idx)
                evp_pkg::REG_OUTER_TPID: r_cfg.outer_tpid  <= pwdata[15:0];
                evp_pkg::REG_TPID_A:     r_cfg.tag_tpid[0] <= pwdata[15:0];
                evp_pkg::REG_TPID_B:     r_cfg.tag_tpid[1] <= pwdata[15:0];
                evp_pkg::REG_TPID_C:     r_cfg.tag_tpid[2] <= pwdata[15:0];
                evp_pkg::REG_TPID_D:     r_cfg.tag_tpid[3] <= pwdata[15:0];
                evp_pkg::REG_TPID_E:     r_cfg.tag_tpid[4] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            evp_pkg::REG_OUTER_TPID: prdata = {16'd0, r_cfg.outer_tpid};
            evp_pkg::REG_TPID_A:     prdata = {16'd0, r_cfg.tag_tpid[0]};
            evp_pkg::REG_TPID_B:     prdata = {16'd0, r_cfg.tag_tpid[1]};
            evp_pkg::REG_TPID_C:     prdata = {16'd0, r_cfg.tag_tpid[2]};
            evp_pkg::REG_TPID_D:     prdata = {16'd0, r_cfg.tag_tpid[3]};
            evp_pkg::REG_TPID_E:     prdata = {16'd0, r_cfg.tag_tpid[4]};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    evp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_data),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_res    (res)
    );

    // result register: refilled in the same cycle its word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= in_accept & emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/core/evp_checker.sv @@
module evp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input evp_pkg::t_out o_out_data
);

    // held word stays put while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed under stall");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no held result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_vid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.vlan_id == o_out_data.outer_tci[11:0])
        else $error("vlan id does not match tag control word");

    a_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != evp_pkg::ST_TOO_MANY |->
            (o_out_data.tag_layers <= 4'd1 && o_out_data.tag_class == evp_pkg::CLS_ONE) ||
            (o_out_data.tag_layers == 4'd2 && o_out_data.tag_class == evp_pkg::CLS_TWO) ||
            (o_out_data.tag_layers > 4'd2 && o_out_data.tag_class == evp_pkg::CLS_MORE))
        else $error("tag class inconsistent with tag count");

endmodule

bind ethernet_vlan_stack_parser evp_checker u_evp_checker (.*);
